/* rtl/tlfq_pkg.sv */
// Shared types and constants of the three-level feedback queue scheduler.
// No dependencies.
package tlfq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_LEVELS  = 3;
  localparam int NUM_TASKS   = 64;
  localparam int ID_W        = 6;
  localparam int LVL_W       = 2;
  localparam int POS_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] MODE_ADD      = 3'd0;
  localparam logic [2:0] MODE_MARK_RUN = 3'd1;
  localparam logic [2:0] MODE_MARK_BLK = 3'd2;
  localparam logic [2:0] MODE_PICK     = 3'd3;
  localparam logic [2:0] MODE_FINISH   = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BUSY     = 2'd1;
  localparam logic [1:0] STATUS_NO_PICK  = 2'd2;

  localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MID = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LOW = 2'd2;

  typedef struct packed {
    logic [2:0]      mode;
    logic [ID_W-1:0] task_id;
    logic [7:0]      ticks_used;
  } tlfq_in_t;

  typedef struct packed {
    logic [ID_W-1:0]  picked_id;
    logic [LVL_W-1:0] picked_level;
    logic             found;
    logic [1:0]       status;
  } tlfq_out_t;

  // Memory request: one write and one read per cycle
  typedef struct packed {
    logic             we;
    logic [LVL_W-1:0] wlvl;
    logic [POS_W-1:0] wpos;
    logic [ID_W-1:0]  wdata;
    logic [LVL_W-1:0] rlvl;
    logic [POS_W-1:0] rpos;
  } tlfq_mreq_t;

endpackage

/* rtl/tlfq_qram.sv */
// Queue storage: all three levels in one synchronous RAM, registered read.
// Depends on tlfq_pkg.
module tlfq_qram import tlfq_pkg::*; (
  input  logic            clk,
  input  tlfq_mreq_t      req,
  output logic [ID_W-1:0] rdata
);

  logic [ID_W-1:0] mem [NUM_LEVELS][QUEUE_DEPTH];

  // Write one entry, read one entry
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wlvl][req.wpos] <= req.wdata;
    end
    rdata <= mem[req.rlvl][req.rpos];
  end

endmodule

/* rtl/tlfq_ctrl.sv */
// Scheduler sequencer: counts, runnable bits, outstanding task, queue passes.
// Depends on tlfq_pkg and drives tlfq_qram through a request struct.
module tlfq_ctrl import tlfq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  tlfq_in_t        in_data,
  input  logic [7:0]      slice_top,
  input  logic [7:0]      slice_middle,
  output logic            busy,
  output logic            out_valid,
  output tlfq_out_t       out_data,
  output tlfq_mreq_t      mreq,
  input  logic [ID_W-1:0] rdata
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r [NUM_LEVELS];
  logic [CNT_W-1:0]       cnt_nxt [NUM_LEVELS];
  logic [NUM_TASKS-1:0]   run_r, run_nxt;
  logic [ID_W-1:0]        oid_r, oid_nxt;
  logic [LVL_W-1:0]       olvl_r, olvl_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic                   is_add_r, is_add_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic [LVL_W-1:0]       lvl_r, lvl_nxt;
  logic [CNT_W-1:0]       rd_r, rd_nxt;
  logic [CNT_W-1:0]       wr_r, wr_nxt;
  logic                   pv_r, pv_nxt;
  logic                   found_r, found_nxt;
  logic [ID_W-1:0]        fid_r, fid_nxt;
  logic                   outv_r, outv_nxt;
  tlfq_out_t              outd_r, outd_nxt;
  logic [CNT_W-1:0]       cur_cnt;
  logic                   skip;
  logic [LVL_W-1:0]       flvl;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = outv_r;
  assign out_data  = outd_r;
  assign cur_cnt   = cnt_r[lvl_r];

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;
    oid_nxt    = oid_r;
    olvl_nxt   = olvl_r;
    ovalid_nxt = ovalid_r;
    is_add_nxt = is_add_r;
    id_nxt     = id_r;
    lvl_nxt    = lvl_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    pv_nxt     = 1'b0;
    found_nxt  = found_r;
    fid_nxt    = fid_r;
    outv_nxt   = 1'b0;
    outd_nxt   = '0;
    mreq       = '0;
    mreq.rlvl  = lvl_r;
    mreq.rpos  = rd_r[POS_W-1:0];
    skip       = 1'b0;
    flvl       = olvl_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_data.mode) inside
            MODE_ADD, MODE_PICK: begin
              if (in_data.mode == MODE_PICK && ovalid_r) begin
                outv_nxt        = 1'b1;
                outd_nxt.status = STATUS_BUSY;
              end else begin
                // start a compaction pass at the top level
                state_nxt  = ST_SCAN;
                is_add_nxt = (in_data.mode == MODE_ADD);
                id_nxt     = in_data.task_id;
                lvl_nxt    = LVL_TOP;
                rd_nxt     = '0;
                wr_nxt     = '0;
                found_nxt  = 1'b0;
              end
            end
            MODE_MARK_RUN: begin
              run_nxt[in_data.task_id] = 1'b1;
              outv_nxt = 1'b1;
            end
            MODE_MARK_BLK: begin
              run_nxt[in_data.task_id] = 1'b0;
              outv_nxt = 1'b1;
            end
            MODE_FINISH: begin
              outv_nxt = 1'b1;
              if (!ovalid_r) begin
                outd_nxt.status = STATUS_NO_PICK;
              end else begin
                // demote on an exact slice match, append to the tail
                if (olvl_r == LVL_TOP && in_data.ticks_used == slice_top) begin
                  flvl = LVL_MID;
                end else if (olvl_r == LVL_MID && in_data.ticks_used == slice_middle) begin
                  flvl = LVL_LOW;
                end
                if (cnt_r[flvl] < CNT_W'(QUEUE_DEPTH)) begin
                  mreq.we    = 1'b1;
                  mreq.wlvl  = flvl;
                  mreq.wpos  = cnt_r[flvl][POS_W-1:0];
                  mreq.wdata = oid_r;
                  cnt_nxt[flvl] = cnt_r[flvl] + 1'b1;
                end
                ovalid_nxt = 1'b0;
              end
            end
            default: begin
              outv_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // issue the next read of the level
        if (rd_r < cur_cnt) begin
          rd_nxt = rd_r + 1'b1;
          pv_nxt = 1'b1;
        end
        // keep or drop the entry that came back
        if (pv_r) begin
          skip = is_add_r ? (rdata == id_r) : (!found_r && run_r[rdata]);
          if (skip && !is_add_r) begin
            found_nxt = 1'b1;
            fid_nxt   = rdata;
          end else if (!skip) begin
            mreq.we    = 1'b1;
            mreq.wlvl  = lvl_r;
            mreq.wpos  = wr_r[POS_W-1:0];
            mreq.wdata = rdata;
            wr_nxt     = wr_r + 1'b1;
          end
        end
        // close the level
        if (!(rd_r < cur_cnt) && !pv_r) begin
          cnt_nxt[lvl_r] = wr_r;
          rd_nxt = '0;
          wr_nxt = '0;
          if (is_add_r) begin
            if (lvl_r == LVL_LOW) begin
              if (cnt_r[LVL_TOP] < CNT_W'(QUEUE_DEPTH)) begin
                mreq.we    = 1'b1;
                mreq.wlvl  = LVL_TOP;
                mreq.wpos  = cnt_r[LVL_TOP][POS_W-1:0];
                mreq.wdata = id_r;
                cnt_nxt[LVL_TOP] = cnt_r[LVL_TOP] + 1'b1;
              end
              if (ovalid_r && oid_r == id_r) begin
                ovalid_nxt = 1'b0;
              end
              state_nxt = ST_IDLE;
              outv_nxt  = 1'b1;
            end else begin
              lvl_nxt = lvl_r + 1'b1;
            end
          end else if (found_r || lvl_r == LVL_LOW) begin
            state_nxt = ST_IDLE;
            outv_nxt  = 1'b1;
            if (found_r) begin
              ovalid_nxt            = 1'b1;
              oid_nxt               = fid_r;
              olvl_nxt              = lvl_r;
              outd_nxt.found        = 1'b1;
              outd_nxt.picked_id    = fid_r;
              outd_nxt.picked_level = lvl_r;
            end
          end else begin
            lvl_nxt = lvl_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        cnt_r[l] <= '0;
      end
      run_r    <= '0;
      oid_r    <= '0;
      olvl_r   <= '0;
      ovalid_r <= 1'b0;
      pv_r     <= 1'b0;
      outv_r   <= 1'b0;
      outd_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      run_r    <= run_nxt;
      oid_r    <= oid_nxt;
      olvl_r   <= olvl_nxt;
      ovalid_r <= ovalid_nxt;
      pv_r     <= pv_nxt;
      outv_r   <= outv_nxt;
      outd_r   <= outd_nxt;
    end
    is_add_r <= is_add_nxt;
    id_r     <= id_nxt;
    lvl_r    <= lvl_nxt;
    rd_r     <= rd_nxt;
    wr_r     <= wr_nxt;
    found_r  <= found_nxt;
    fid_r    <= fid_nxt;
  end

endmodule

/* rtl/three_level_feedback_queue_scheduler.sv */
// Channel  | ports                              | handshake
// request  | start, busy, in_data               | taken when start & !busy
// result   | out_valid, out_data                | one-cycle strobe, no backpressure
// config   | cfg_valid, cfg_ready, cfg_index/.. | taken when cfg_valid & cfg_ready
//
// Mark, finish and error cases answer in the cycle after the request.
// Add and pick run a read-modify-write pass over the levels through the
// single-port-pair queue RAM: add visits every level, pick stops after the
// level holding its pick. Reset is synchronous, active low; the queue RAM
// needs no clearing pass. Results cannot be stalled.
// Top level of the three-level feedback queue scheduler: slice registers,
// sequencer and queue RAM. Depends on tlfq_pkg, tlfq_ctrl, tlfq_qram.
module three_level_feedback_queue_scheduler import tlfq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  tlfq_in_t   in_data,
  output logic       out_valid,
  output tlfq_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam logic CFG_SLICE_TOP = 1'b0;
  localparam logic CFG_SLICE_MID = 1'b1;

  logic [7:0]      slice_top_r;
  logic [7:0]      slice_mid_r;
  tlfq_mreq_t      mreq;
  logic [ID_W-1:0] rdata;

  assign cfg_ready = 1'b1;

  // Hold slice registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_top_r <= 8'd1;
      slice_mid_r <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLICE_TOP: slice_top_r <= cfg_wdata;
        CFG_SLICE_MID: slice_mid_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tlfq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start & ~busy),
    .in_data      (in_data),
    .slice_top    (slice_top_r),
    .slice_middle (slice_mid_r),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .mreq         (mreq),
    .rdata        (rdata)
  );

  tlfq_qram u_qram (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.status == STATUS_OK)
    else $error("found with error status");

  a_mark_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.mode == MODE_MARK_RUN || in_data.mode == MODE_MARK_BLK)
    |=> out_valid)
    else $error("mark result late");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.picked_level != 2'd3)
    else $error("bad level");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

endmodule

/* dv/three_level_feedback_queue_scheduler_tb.sv */
// Self-checking testbench for the three-level feedback queue scheduler.
// Predicts every result in-house from typed state; depends on tlfq_pkg and the RTL.
`timescale 1ns / 1ps

module three_level_feedback_queue_scheduler_tb;
  import tlfq_pkg::*;

  localparam bit REG_SLICE_TOP = 1'b0;
  localparam bit REG_SLICE_MID = 1'b1;
  localparam int DRAIN_CYCLES  = 3 * (QUEUE_DEPTH + 2) + 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  tlfq_in_t   in_data = '0;
  logic       out_valid;
  tlfq_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_wdata = '0;

  three_level_feedback_queue_scheduler DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Scheduler mirror state
  logic [ID_W-1:0]  lvl_q [NUM_LEVELS][QUEUE_DEPTH];
  int               lvl_cnt [NUM_LEVELS];
  logic [NUM_TASKS-1:0] run_bit;
  logic [LVL_W-1:0] task_lvl [NUM_TASKS];
  logic [ID_W-1:0]  held_id;
  logic             held_valid;
  logic [7:0]       slice_top_r;
  logic [7:0]       slice_mid_r;

  tlfq_in_t  pending_reqs [$];
  tlfq_out_t sched_expect [$];
  int        errors = 0;
  int        n_accepted = 0;
  int        n_results = 0;
  int        n_found = 0;
  int        burst_left = 4;
  int        gap_left = 0;

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void queue_append(input int lvl, input logic [ID_W-1:0] id);
    if (lvl_cnt[lvl] < QUEUE_DEPTH) begin
      lvl_q[lvl][lvl_cnt[lvl]] = id;
      lvl_cnt[lvl]++;
    end
    task_lvl[id] = LVL_W'(lvl);
  endfunction

  // Apply one request to the mirror and return the result it should give
  function automatic tlfq_out_t predict_sched(input tlfq_in_t r);
    tlfq_out_t o;
    int lvl;
    int i;
    int w;
    logic [ID_W-1:0] cand;
    logic [LVL_W-1:0] cur;
    o = '0;
    case (r.mode)
      MODE_ADD: begin
        for (lvl = 0; lvl < NUM_LEVELS; lvl++) begin
          w = 0;
          for (i = 0; i < lvl_cnt[lvl]; i++)
            if (lvl_q[lvl][i] != r.task_id) begin
              lvl_q[lvl][w] = lvl_q[lvl][i];
              w++;
            end
          lvl_cnt[lvl] = w;
        end
        if (held_valid && held_id == r.task_id) held_valid = 1'b0;
        queue_append(0, r.task_id);
      end
      MODE_MARK_RUN: run_bit[r.task_id] = 1'b1;
      MODE_MARK_BLK: run_bit[r.task_id] = 1'b0;
      MODE_PICK: begin
        if (held_valid) begin
          o.status = STATUS_BUSY;
        end else begin
          for (lvl = 0; lvl < NUM_LEVELS && !o.found; lvl++)
            for (i = 0; i < lvl_cnt[lvl] && !o.found; i++) begin
              cand = lvl_q[lvl][i];
              if (run_bit[cand]) begin
                for (w = i; w + 1 < lvl_cnt[lvl]; w++) lvl_q[lvl][w] = lvl_q[lvl][w + 1];
                lvl_cnt[lvl]--;
                task_lvl[cand] = LVL_W'(lvl);
                held_id = cand;
                held_valid = 1'b1;
                o.picked_id = cand;
                o.picked_level = LVL_W'(lvl);
                o.found = 1'b1;
              end
            end
        end
      end
      MODE_FINISH: begin
        if (!held_valid) begin
          o.status = STATUS_NO_PICK;
        end else begin
          cur = task_lvl[held_id];
          if (cur == LVL_TOP && r.ticks_used == slice_top_r) queue_append(LVL_MID, held_id);
          else if (cur == LVL_MID && r.ticks_used == slice_mid_r) queue_append(LVL_LOW, held_id);
          else queue_append(int'(cur), held_id);
          held_valid = 1'b0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Driver: accept on start & !busy, then present the next request or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        sched_expect.push_back(predict_sched(in_data));
        n_accepted++;
      end
      if (start && busy) begin
        // hold the request until taken
      end else if (pending_reqs.size() > 0 && gap_left == 0) begin
        in_data <= pending_reqs.pop_front();
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Monitor: every strobe must match the oldest expectation
  always @(posedge clk) begin
    tlfq_out_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (sched_expect.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        e = sched_expect.pop_front();
        if (e.found) n_found++;
        if (out_data.picked_id !== e.picked_id)
          report_mismatch($sformatf("picked_id %0d, want %0d", out_data.picked_id, e.picked_id));
        if (out_data.picked_level !== e.picked_level)
          report_mismatch($sformatf("picked_level %0d, want %0d",
                                    out_data.picked_level, e.picked_level));
        if (out_data.found !== e.found)
          report_mismatch($sformatf("found %0b, want %0b", out_data.found, e.found));
        if (out_data.status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data.status, e.status));
      end
    end
  end

  task automatic cfg_write(input bit idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SLICE_TOP) slice_top_r = val;
    else slice_mid_r = val;
  endtask

  // Wait until the sender is empty and every result is back
  task automatic drain();
    wait (pending_reqs.size() == 0 && !start && sched_expect.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic tlfq_in_t mk(input logic [2:0] m, input logic [ID_W-1:0] id,
                                  input logic [7:0] t);
    tlfq_in_t r;
    r.mode = m;
    r.task_id = id;
    r.ticks_used = t;
    return r;
  endfunction

  // Random request biased toward well-formed pick/finish traffic
  function automatic tlfq_in_t rand_req(input int pool);
    int sel;
    logic [ID_W-1:0] id;
    logic [7:0] t;
    sel = $urandom_range(0, 99);
    id = ($urandom_range(0, 4) == 0) ? ID_W'($urandom_range(0, 63))
                                     : ID_W'($urandom_range(0, pool - 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t = slice_top_r;
      4, 5, 6:    t = slice_mid_r;
      default:    t = 8'($urandom_range(0, 255));
    endcase
    if (sel < 16) return mk(MODE_ADD, id, 8'($urandom));
    if (sel < 36) return mk(MODE_MARK_RUN, id, 8'($urandom));
    if (sel < 44) return mk(MODE_MARK_BLK, id, 8'($urandom));
    if (sel < 70) return mk(MODE_PICK, id, 8'($urandom));
    if (sel < 97) return mk(MODE_FINISH, id, t);
    return mk(3'(MODE_FINISH + 1 + $urandom_range(0, 2)), id, 8'($urandom));
  endfunction

  initial begin
    int ph;
    int k;
    int pool;
    logic [7:0] st;
    logic [7:0] sm;
    for (k = 0; k < NUM_LEVELS; k++) lvl_cnt[k] = 0;
    for (k = 0; k < NUM_TASKS; k++) task_lvl[k] = LVL_TOP;
    run_bit = '0;
    held_id = '0;
    held_valid = 1'b0;
    slice_top_r = 8'd1;
    slice_mid_r = 8'd2;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: error statuses, demotion, requeue, add of held task, unused modes
    pending_reqs.push_back(mk(MODE_PICK, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_FINISH, 6'd0, 8'd1));
    pending_reqs.push_back(mk(MODE_ADD, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_ADD, 6'd63, 8'd255));
    pending_reqs.push_back(mk(MODE_PICK, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_MARK_RUN, 6'd63, 8'd0));
    pending_reqs.push_back(mk(MODE_MARK_RUN, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_PICK, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_PICK, 6'd63, 8'd0));
    pending_reqs.push_back(mk(MODE_MARK_BLK, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_FINISH, 6'd0, 8'd1));
    pending_reqs.push_back(mk(MODE_PICK, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_FINISH, 6'd0, 8'd255));
    pending_reqs.push_back(mk(MODE_PICK, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_ADD, 6'd63, 8'd0));
    pending_reqs.push_back(mk(MODE_FINISH, 6'd0, 8'd1));
    pending_reqs.push_back(mk(MODE_MARK_RUN, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_PICK, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_FINISH, 6'd0, 8'd2));
    pending_reqs.push_back(mk(MODE_PICK, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_FINISH, 6'd0, 8'd2));
    pending_reqs.push_back(mk(MODE_PICK, 6'd0, 8'd0));
    pending_reqs.push_back(mk(MODE_FINISH, 6'd0, 8'd2));
    pending_reqs.push_back(mk(3'(MODE_FINISH + 1), 6'd63, 8'd255));
    pending_reqs.push_back(mk(3'(MODE_FINISH + 3), 6'd63, 8'd255));
    drain();

    // Random phases, each under its own slice setting; the sender pauses between them
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin st = 8'd255; sm = 8'd255; end
        1: begin st = 8'd1;   sm = 8'd255; end
        2: begin st = 8'd255; sm = 8'd1;   end
        3: begin st = 8'd3;   sm = 8'd7;   end
        default: begin st = 8'($urandom_range(1, 255)); sm = 8'($urandom_range(1, 255)); end
      endcase
      cfg_write(REG_SLICE_TOP, st);
      cfg_write(REG_SLICE_MID, sm);
      pool = (ph == 4) ? 64 : $urandom_range(4, 16);
      for (k = 0; k < 255; k++) pending_reqs.push_back(rand_req(pool));
      drain();
    end

    $display("Covered %0d requests, %0d results, %0d successful picks,",
             n_accepted, n_results, n_found);
    $display("under six slice settings including both extremes.");
    if (errors == 0) begin
      $display("three_level_feedback_queue_scheduler_tb OK");
    end else begin
      $display("three_level_feedback_queue_scheduler_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for scheduler results");
    $display("three_level_feedback_queue_scheduler_tb NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
rtl/tlfq_pkg.sv
rtl/tlfq_qram.sv
rtl/tlfq_ctrl.sv
rtl/three_level_feedback_queue_scheduler.sv
dv/three_level_feedback_queue_scheduler_tb.sv
